/* rtl/vbt_pkg.sv */
// Shared constants, types and helpers for the version barrier tracker.
package vbt_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_SERVERS = 16;
  localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int VER_W  = 64;
  localparam int MASK_W = 16;
  localparam int SIDX_W = 4;
  localparam int ERR_W  = 2;

  // Command queue between front and back
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  // Item modes
  localparam logic MODE_ANNOUNCE = 1'b0;
  localparam logic MODE_PASS     = 1'b1;

  // Result codes
  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_VERSION = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL    = 2'd2;

  // Classified command word
  typedef struct packed {
    logic              mode;
    logic [VER_W-1:0]  version;
    logic [MASK_W-1:0] mask;
    logic [MASK_W-1:0] clear;
  } cmd_t;

  // Command queue status
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Mask of server bits that exist
  function automatic logic [MASK_W-1:0] server_bits();
    logic [MASK_W-1:0] bits;
    bits = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < MAX_SERVERS) begin
        bits[i] = 1'b1;
      end
    end
    return bits;
  endfunction

  // Slot of the entry at a given position behind the head
  function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0]  head,
                                                input logic [COUNT_W-1:0] pos);
    logic [COUNT_W:0] sum;
    sum = (COUNT_W+1)'(head) + (COUNT_W+1)'(pos);
    if (sum >= (COUNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (COUNT_W+1)'(QUEUE_DEPTH);
    end
    return SLOT_W'(sum);
  endfunction

endpackage

/* rtl/vbt_front.sv */
// Front end: accepts items, classifies them and stages them for the command queue.
module vbt_front import vbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_mode,
  input  logic [VER_W-1:0]  in_version,
  input  logic [MASK_W-1:0] in_server_mask,
  input  logic [SIDX_W-1:0] in_server_index,
  input  fifo_stat_t        fifo_stat,
  output logic              push,
  output cmd_t              push_cmd
);

  logic stage_vld_r, stage_vld_nxt;
  cmd_t stage_r, stage_nxt;
  logic accept;
  cmd_t cls;

  // Classify: trim the server mask, turn the index into a clear bit
  always_comb begin
    cls.mode    = in_mode;
    cls.version = in_version;
    cls.mask    = in_server_mask & server_bits();
    cls.clear   = '0;
    if (int'(in_server_index) < MAX_SERVERS) begin
      cls.clear = MASK_W'(1) << in_server_index;
    end
  end

  assign busy     = stage_vld_r & fifo_stat.full;
  assign accept   = start & ~busy;
  assign push     = stage_vld_r & ~fifo_stat.full;
  assign push_cmd = stage_r;

  // Hold the staged word until the queue takes it
  always_comb begin
    stage_vld_nxt = stage_vld_r;
    stage_nxt     = stage_r;
    if (push) begin
      stage_vld_nxt = 1'b0;
    end
    if (accept) begin
      stage_vld_nxt = 1'b1;
      stage_nxt     = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
    end
    stage_r <= stage_nxt;
  end

endmodule

/* rtl/vbt_cmd_fifo.sv */
// Short command queue between the front end and the back end.
module vbt_cmd_fifo import vbt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmd_t       push_cmd,
  input  logic       pop,
  output cmd_t       pop_cmd,
  output fifo_stat_t stat
);

  cmd_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign pop_cmd    = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/vbt_back.sv */
// Back end: holds the version queue, applies commands, drops passed entries.
module vbt_back import vbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  fifo_stat_t        fifo_stat,
  input  cmd_t              pop_cmd,
  output logic              pop,
  output logic              out_valid,
  output logic [VER_W-1:0]  out_oldest_version,
  output logic [ERR_W-1:0]  out_error_code
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [VER_W-1:0]   ver_r  [QUEUE_DEPTH];
  logic [MASK_W-1:0]  pend_r [QUEUE_DEPTH];
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [VER_W-1:0]   newest_r, newest_nxt;
  logic [COUNT_W-1:0] pos_r, pos_nxt;
  logic [COUNT_W-1:0] last_r, last_nxt;
  logic               matched_r, matched_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;
  logic [VER_W-1:0]   oldest_r, oldest_nxt;
  logic               out_valid_r;
  logic [VER_W-1:0]   out_ver_r;
  logic [ERR_W-1:0]   out_err_r;

  logic [SLOT_W-1:0]  walk_slot;
  logic [SLOT_W-1:0]  app_slot;
  logic [VER_W-1:0]   walk_ver;
  logic [MASK_W-1:0]  walk_pend;
  logic [MASK_W-1:0]  pend_eff;
  logic               hit;
  logic               append;
  logic               pend_wr;

  assign walk_slot = slot_at(head_r, pos_r);
  assign app_slot  = slot_at(head_r, count_r);
  assign walk_ver  = ver_r[walk_slot];
  assign walk_pend = pend_r[walk_slot];
  assign hit       = (cmd_r.mode == MODE_PASS) && !matched_r && (walk_ver == cmd_r.version);
  assign pend_eff  = hit ? (walk_pend & ~cmd_r.clear) : walk_pend;
  assign pend_wr   = (state_r == S_WALK) && hit;

  // Sequence: take a command, walk the live entries, retire the prefix
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    newest_nxt  = newest_r;
    pos_nxt     = pos_r;
    last_nxt    = last_r;
    matched_nxt = matched_r;
    cmd_nxt     = cmd_r;
    err_nxt     = err_r;
    oldest_nxt  = oldest_r;
    pop         = 1'b0;
    append      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!fifo_stat.empty) begin
          pop         = 1'b1;
          cmd_nxt     = pop_cmd;
          pos_nxt     = '0;
          last_nxt    = '0;
          matched_nxt = 1'b0;
          err_nxt     = ERR_OK;
          if (pop_cmd.mode == MODE_ANNOUNCE) begin
            if (pop_cmd.version == '0 || pop_cmd.version <= newest_r) begin
              err_nxt = ERR_VERSION;
            end else if (count_r == COUNT_W'(QUEUE_DEPTH)) begin
              err_nxt = ERR_FULL;
            end else begin
              append     = 1'b1;
              count_nxt  = count_r + 1'b1;
              newest_nxt = pop_cmd.version;
            end
          end
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (hit) begin
          matched_nxt = 1'b1;
        end
        if (pos_r == '0) begin
          oldest_nxt = walk_ver;
        end
        if (pend_eff == '0) begin
          last_nxt   = pos_r;
          oldest_nxt = walk_ver;
        end
        pos_nxt = pos_r + 1'b1;
        if (pos_r == count_r - 1'b1) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        head_nxt  = slot_at(head_r, last_r);
        count_nxt = count_r - last_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= COUNT_W'(1);
      newest_r    <= '0;
      pos_r       <= '0;
      last_r      <= '0;
      matched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      newest_r    <= newest_nxt;
      pos_r       <= pos_nxt;
      last_r      <= last_nxt;
      matched_r   <= matched_nxt;
      out_valid_r <= (state_r == S_FINISH);
    end
    cmd_r    <= cmd_nxt;
    err_r    <= err_nxt;
    oldest_r <= oldest_nxt;
    if (state_r == S_FINISH) begin
      out_ver_r <= oldest_r;
      out_err_r <= err_r;
    end
  end

  // Entry store: append in the take cycle, clear a server bit during the walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ver_r[i]  <= '0;
        pend_r[i] <= '0;
      end
    end else begin
      if (append) begin
        ver_r[app_slot]  <= pop_cmd.version;
        pend_r[app_slot] <= pop_cmd.mask;
      end else if (pend_wr) begin
        pend_r[walk_slot] <= pend_eff;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_oldest_version = out_ver_r;
  assign out_error_code     = out_err_r;

endmodule

/* rtl/version_barrier_tracker_top.sv */
// Top level of the version barrier tracker.
//
// Keeps an ordered queue of up to QUEUE_DEPTH versions, each with a mask of
// servers still to pass it, and reports the oldest version kept after every
// word. A word is taken when start is high and busy is low; the front end
// stages it into a four-word command queue, so busy rises only when the
// stage and the queue are both full. The back end handles one word at a time:
// it takes the word, walks the live queue entries one per cycle to clear the
// server bit and find the last empty entry, and then retires the passed
// entries. Exactly one result per word appears for a single cycle on the out_
// ports, marked by out_valid, from a register that the retire step loads;
// the receiver cannot stall it.
module version_barrier_tracker_top import vbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_mode,
  input  logic [VER_W-1:0]  in_version,
  input  logic [MASK_W-1:0] in_server_mask,
  input  logic [SIDX_W-1:0] in_server_index,
  output logic              out_valid,
  output logic [VER_W-1:0]  out_oldest_version,
  output logic [ERR_W-1:0]  out_error_code
);

  fifo_stat_t fifo_stat;
  logic       push;
  cmd_t       push_cmd;
  logic       pop;
  cmd_t       pop_cmd;

  // Accept and classify words
  vbt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_version      (in_version),
    .in_server_mask  (in_server_mask),
    .in_server_index (in_server_index),
    .fifo_stat       (fifo_stat),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  // Decouple front and back
  vbt_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .stat     (fifo_stat)
  );

  // Carry out commands on the version queue
  vbt_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .fifo_stat          (fifo_stat),
    .pop_cmd            (pop_cmd),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_oldest_version (out_oldest_version),
    .out_error_code     (out_error_code)
  );

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the version barrier tracker top level.
`timescale 1ns / 1ps

module tb_top import vbt_pkg::*;;

  localparam int WORD_TARGET = 1850;
  localparam int DRAIN_CYCLES = 40;

  // Expected result word
  typedef struct packed {
    logic [VER_W-1:0] oldest;
    logic [ERR_W-1:0] err;
  } barrier_result_t;

  // Model of the version queue plus the expected result words in order
  class barrier_scoreboard;
    logic [VER_W-1:0]  slot_ver  [QUEUE_DEPTH];
    logic [MASK_W-1:0] slot_pend [QUEUE_DEPTH];
    logic [MASK_W-1:0] live_servers;
    int unsigned       head;
    int unsigned       count;
    barrier_result_t   expected_results [$];
    int                fail_count;

    function new();
      live_servers = '0;
      for (int i = 0; i < MASK_W; i++) begin
        if (i < MAX_SERVERS) begin
          live_servers[i] = 1'b1;
        end
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        slot_ver[i]  = '0;
        slot_pend[i] = '0;
      end
      head       = 0;
      count      = 1;
      fail_count = 0;
    endfunction

    function int unsigned slot(int unsigned pos);
      return (head + pos) % QUEUE_DEPTH;
    endfunction

    function logic [VER_W-1:0] newest();
      return slot_ver[slot(count - 1)];
    endfunction

    // Apply one accepted word and queue the result it must give
    function void note_word(logic mode, logic [VER_W-1:0] ver,
                            logic [MASK_W-1:0] mask, logic [SIDX_W-1:0] sidx);
      logic [ERR_W-1:0] err;
      int unsigned      s;
      int unsigned      last;
      bit               found;
      barrier_result_t  res;
      err   = ERR_OK;
      last  = 0;
      found = 1'b0;
      if (mode == MODE_ANNOUNCE) begin
        if (ver == '0 || ver <= newest()) begin
          err = ERR_VERSION;
        end else if (count >= QUEUE_DEPTH) begin
          err = ERR_FULL;
        end else begin
          s            = slot(count);
          slot_ver[s]  = ver;
          slot_pend[s] = mask & live_servers;
          count++;
        end
      end else begin
        // Clear the bit in the first exact match only
        for (int unsigned i = 0; i < count; i++) begin
          s = slot(i);
          if (slot_ver[s] == ver) begin
            if (int'(sidx) < MAX_SERVERS) begin
              slot_pend[s][sidx] = 1'b0;
            end
            break;
          end
        end
      end
      // Drop everything in front of the last fully passed entry
      for (int unsigned i = 0; i < count; i++) begin
        if (slot_pend[slot(i)] == '0) begin
          last  = i;
          found = 1'b1;
        end
      end
      if (found && last > 0) begin
        head  = slot(last);
        count = count - last;
      end
      res.oldest = slot_ver[head];
      res.err    = err;
      expected_results.insert(expected_results.size(), res);
    endfunction

    // Compare one result word with the oldest expectation
    function void check_result(logic [VER_W-1:0] oldest, logic [ERR_W-1:0] err);
      barrier_result_t res;
      if (expected_results.size() == 0) begin
        $error("result word with none expected: oldest_version %h error_code %0d",
               oldest, err);
        fail_count++;
        return;
      end
      res = expected_results[0];
      expected_results.delete(0);
      if (oldest !== res.oldest) begin
        $error("oldest_version: expected %h, got %h", res.oldest, oldest);
        fail_count++;
      end
      if (err !== res.err) begin
        $error("error_code: expected %0d, got %0d", res.err, err);
        fail_count++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_mode;
  logic [VER_W-1:0]  in_version;
  logic [MASK_W-1:0] in_server_mask;
  logic [SIDX_W-1:0] in_server_index;
  logic              out_valid;
  logic [VER_W-1:0]  out_oldest_version;
  logic [ERR_W-1:0]  out_error_code;

  barrier_scoreboard sb;
  int                words_sent;

  version_barrier_tracker_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_version         (in_version),
    .in_server_mask     (in_server_mask),
    .in_server_index    (in_server_index),
    .out_valid          (out_valid),
    .out_oldest_version (out_oldest_version),
    .out_error_code     (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Check every strobed result word
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      sb.check_result(out_oldest_version, out_error_code);
    end
  end

  // Offer one word and hold it until the block takes it
  task automatic send_word(input logic mode, input logic [VER_W-1:0] ver,
                           input logic [MASK_W-1:0] mask,
                           input logic [SIDX_W-1:0] sidx);
    start           <= 1'b1;
    in_mode         <= mode;
    in_version      <= ver;
    in_server_mask  <= mask;
    in_server_index <= sidx;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_word(mode, ver, mask, sidx);
    words_sent++;
  endtask

  // Lower start for a while, with junk on the payload
  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start           <= 1'b0;
      in_mode         <= 1'($urandom);
      in_version      <= {$urandom, $urandom};
      in_server_mask  <= 16'($urandom);
      in_server_index <= 4'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Build a random word, mostly well-formed against the current queue
  task automatic next_random_word(output logic mode, output logic [VER_W-1:0] ver,
                                  output logic [MASK_W-1:0] mask,
                                  output logic [SIDX_W-1:0] sidx);
    int unsigned       pick;
    int unsigned       pos;
    int unsigned       s;
    int unsigned       nbits;
    int unsigned       announce_pct;
    logic [VER_W-1:0]  top;
    logic [MASK_W-1:0] pend;
    top  = sb.newest();
    pick = $urandom_range(0, 99);
    mask = 16'($urandom);
    sidx = 4'($urandom);
    if (sb.count < 4) begin
      announce_pct = 70;
    end else if (sb.count < 12) begin
      announce_pct = 45;
    end else begin
      announce_pct = 30;
    end
    if (pick < 10) begin
      // Noise: bad announces or passes of arbitrary versions
      case ($urandom_range(0, 2))
        0: begin
          mode = MODE_ANNOUNCE;
          ver  = '0;
        end
        1: begin
          mode = MODE_ANNOUNCE;
          ver  = {$urandom, $urandom};
          if (ver > top) begin
            ver = ver % (top + 1);
          end
        end
        default: begin
          mode = MODE_PASS;
          ver  = {$urandom, $urandom};
        end
      endcase
    end else if ($urandom_range(0, 99) < announce_pct) begin
      // Announce above the newest, usually by a small step
      mode = MODE_ANNOUNCE;
      if ($urandom_range(0, 49) == 0) begin
        ver = top + (64'd1 << $urandom_range(8, 56));
      end else begin
        ver = top + 64'($urandom_range(1, 3));
      end
      if ($urandom_range(0, 19) != 0) begin
        mask  = '0;
        nbits = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        for (int unsigned j = 0; j < nbits; j++) begin
          mask[$urandom_range(0, MASK_W - 1)] = 1'b1;
        end
      end
    end else begin
      mode = MODE_PASS;
      if ($urandom_range(0, 9) == 0) begin
        // Pass a version that is not in the queue
        ver = ($urandom_range(0, 1) == 0) ? top + 64'($urandom_range(1, 8))
                                          : sb.slot_ver[sb.head] - 64'($urandom_range(1, 8));
      end else begin
        pos = $urandom_range(0, sb.count - 1);
        for (int k = 0; k < 4 && sb.slot_pend[sb.slot(pos)] == '0; k++) begin
          pos = $urandom_range(0, sb.count - 1);
        end
        s    = sb.slot(pos);
        ver  = sb.slot_ver[s];
        pend = sb.slot_pend[s];
        if (pend != '0 && $urandom_range(0, 7) != 0) begin
          while (pend[sidx] == 1'b0) sidx = 4'($urandom);
        end
      end
    end
  endtask

  initial begin : stimulus
    logic              mode;
    logic [VER_W-1:0]  ver;
    logic [MASK_W-1:0] mask;
    logic [SIDX_W-1:0] sidx;
    int                burst;
    int                gap;
    int                drain;

    sb              = new();
    words_sent      = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_mode         = MODE_ANNOUNCE;
    in_version      = '0;
    in_server_mask  = '0;
    in_server_index = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero and equal versions, unmatched pass, full queue, error order
    send_word(MODE_ANNOUNCE, 64'd0, 16'hFFFF, 4'd0);
    send_word(MODE_ANNOUNCE, 64'd1, 16'h8001, 4'd0);
    send_word(MODE_ANNOUNCE, 64'd1, 16'h0000, 4'd0);
    send_word(MODE_PASS, 64'd5, 16'h0000, 4'd0);
    for (int v = 2; v <= 15; v++) begin
      send_word(MODE_ANNOUNCE, 64'(v), (v == 15) ? 16'hFFFF : 16'(16'h0001 << v),
                4'd0);
    end
    send_word(MODE_ANNOUNCE, 64'd100, 16'h0000, 4'd0);
    send_word(MODE_ANNOUNCE, 64'd3, 16'h0000, 4'd0);
    send_word(MODE_PASS, 64'd1, 16'h0000, 4'd0);
    send_word(MODE_PASS, 64'd1, 16'h0000, 4'd0);
    send_word(MODE_PASS, 64'd1, 16'hFFFF, 4'd15);
    hold_off(20);

    // Random bursts with random gaps between them
    while (words_sent < WORD_TARGET) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        next_random_word(mode, ver, mask, sidx);
        send_word(mode, ver, mask, sidx);
      end
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 3);
        2:       gap = $urandom_range(4, 20);
        default: gap = $urandom_range(20, 40);
      endcase
      hold_off(gap);
    end

    // Top of the version range, which closes off further announces
    send_word(MODE_ANNOUNCE, '1, 16'h0001, 4'd0);
    send_word(MODE_ANNOUNCE, '1, 16'h0000, 4'd0);
    send_word(MODE_PASS, '1, 16'h0000, 4'd0);
    start <= 1'b0;

    // Drain outstanding results, then allow for stragglers
    drain = 0;
    while (sb.expected_results.size() != 0 && drain < 10_000) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.expected_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      if (sb.expected_results.size() != 0) begin
        $error("%0d result words never arrived", sb.expected_results.size());
      end
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
